// ----- rtl/sensor_frame_receiver_alarm_core_macros.svh -----
// Assertion macros shared by the frame receiver checker.
`ifndef SENSOR_FRAME_RECEIVER_ALARM_CORE_MACROS_SVH
`define SENSOR_FRAME_RECEIVER_ALARM_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SFRA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfra check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SFRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfra check failed");

`endif

// ----- rtl/sfra_pkg.sv -----
// Shared constants and types of the sensor frame receiver.
package sfra_pkg;

    localparam logic [7:0] CH_START   = 8'h53;  // 'S'
    localparam logic [7:0] CH_HEAD    = 8'h59;  // 'Y'
    localparam logic [7:0] CH_TAIL    = 8'h48;  // 'H'
    localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
    localparam logic [7:0] TEN        = 8'd10;
    localparam logic [7:0] THRESH_RST = 8'd20;

    // Slots 0..6 live in the cell chain; slot 7 is the closing byte itself.
    localparam int unsigned NUM_CELLS = 7;
    localparam logic [2:0]  LAST_SLOT = 3'd7;
    localparam logic [2:0]  PRE_LAST  = 3'd6;

    // Register index decoded from paddr[2].
    localparam logic REG_THRESH = 1'b0;

    // Per-cell control: load overwrites the first cell, shift moves the chain.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // One finished frame.
    typedef struct packed {
        logic       frame_ok;
        logic [7:0] temp_tens_char;
        logic [7:0] temp_units_char;
        logic [7:0] hum_tens_char;
        logic [7:0] hum_units_char;
        logic [7:0] temperature;
        logic       over_threshold;
    } t_result;

endpackage

// ----- rtl/sfra_cell.sv -----
// One byte cell of the frame chain.
module sfra_cell (
    input  logic                 i_clk,
    input  sfra_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]           i_byte,
    output logic [7:0]           o_byte
);
    import sfra_pkg::*;

    logic [7:0] r_byte;

    // Take the neighbor's byte on a shift, or the new byte on a restart load.
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift || i_ctl.load) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// ----- rtl/sfra_eval.sv -----
// Frame check, temperature decode and threshold compare.
module sfra_eval (
    input  logic [7:0]        i_slot0,
    input  logic [7:0]        i_slot1,
    input  logic [7:0]        i_slot2,
    input  logic [7:0]        i_slot3,
    input  logic [7:0]        i_slot4,
    input  logic [7:0]        i_slot5,
    input  logic [7:0]        i_slot6,
    input  logic [7:0]        i_slot7,
    input  logic [7:0]        i_threshold,
    output sfra_pkg::t_result o_result
);
    import sfra_pkg::*;

    logic [7:0]  tens_val;
    logic [7:0]  units_val;
    logic [7:0]  tens_x10;
    logic [7:0]  temp;
    logic        ok;

    // Digit values wrap modulo 256 for non-digit characters.
    assign tens_val  = i_slot3 - CH_ZERO;
    assign units_val = i_slot4 - CH_ZERO;
    assign tens_x10  = tens_val * TEN;
    assign temp      = tens_x10 + units_val;

    // Header "SYY" and trailer 'H'.
    assign ok = (i_slot0 == CH_START) && (i_slot1 == CH_HEAD) &&
                (i_slot2 == CH_HEAD) && (i_slot7 == CH_TAIL);

    always_comb begin
        o_result.frame_ok        = ok;
        o_result.temp_tens_char  = i_slot3;
        o_result.temp_units_char = i_slot4;
        o_result.hum_tens_char   = i_slot5;
        o_result.hum_units_char  = i_slot6;
        o_result.temperature     = temp;
        o_result.over_threshold  = ok && (temp >= i_threshold);
    end

endmodule

// ----- rtl/sensor_frame_receiver_alarm_core.sv -----
// Top level of the sensor frame receiver with temperature alarm.
//
// Input channel (i_rx_valid / o_rx_ready / i_rx_byte): one received serial
// byte per beat. While idle every byte but 'S' is dropped; 'S' opens a frame
// and the next seven bytes fill slots 1 to 7 (an 'S' in slot 1 reopens it).
// The byte that fills slot 7 produces one result beat on the output channel
// (o_res_valid / i_res_ready) in the cycle after it is accepted; all other
// bytes produce nothing. Bytes shift through a chain of seven byte cells, so
// the frame is complete the moment its closing byte arrives. The result sits
// in an output register. Throughput is one byte per cycle, also while the
// result waits; only the byte that would close the next frame is held off
// (o_rx_ready low) until the pending result beat is taken.
// Configuration: APB register 0 (address 0) is the 8-bit temperature
// threshold, reset value 20; write it only while the block is idle.
// Synchronous active-low reset clears the frame position, the receiving
// flag and the output valid; the threshold returns to 20.
module sensor_frame_receiver_alarm_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // serial byte input
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    // frame result output
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic        o_frame_ok,
    output logic [7:0]  o_temp_tens_char,
    output logic [7:0]  o_temp_units_char,
    output logic [7:0]  o_hum_tens_char,
    output logic [7:0]  o_hum_units_char,
    output logic [7:0]  o_temperature,
    output logic        o_over_threshold,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sfra_pkg::*;

    logic [2:0]  r_pos;
    logic [2:0]  n_pos;
    logic        r_receiving;
    logic        n_receiving;
    logic [7:0]  r_threshold;
    logic        r_out_valid;
    t_result     r_out;

    logic        accept;
    logic        start;
    logic        store;
    logic        complete;
    logic        cfg_write;
    t_cell_ctl   head_ctl;
    t_cell_ctl   body_ctl;
    logic [7:0]  cell_q [NUM_CELLS];
    t_result     result;

    // Hold off only the closing byte while a result is still pending.
    assign o_rx_ready = !(r_out_valid && !i_res_ready && r_receiving && (r_pos == PRE_LAST));
    assign accept     = i_rx_valid && o_rx_ready;

    assign start    = accept && (i_rx_byte == CH_START) && (r_pos == '0);
    assign store    = accept && !start && r_receiving;
    assign complete = store && ((r_pos + 3'd1) == LAST_SLOT);

    // Advance the slot position and the receiving flag.
    always_comb begin
        n_pos       = r_pos;
        n_receiving = r_receiving;
        if (start) begin
            n_receiving = 1'b1;
        end else if (complete) begin
            n_pos       = '0;
            n_receiving = 1'b0;
        end else if (store) begin
            n_pos = r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_receiving <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_receiving <= n_receiving;
        end
    end

    // Drive the cell chain: restart loads the first cell, a stored byte shifts all.
    always_comb begin
        head_ctl.load  = start;
        head_ctl.shift = store;
        body_ctl.load  = 1'b0;
        body_ctl.shift = store;
    end

    sfra_cell u_cell_head (
        .i_clk  (i_clk),
        .i_ctl  (head_ctl),
        .i_byte (i_rx_byte),
        .o_byte (cell_q[0])
    );

    for (genvar k = 1; k < NUM_CELLS; k++) begin : g_cell
        sfra_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (body_ctl),
            .i_byte (cell_q[k-1]),
            .o_byte (cell_q[k])
        );
    end

    // At the closing byte cell k holds slot 6-k.
    sfra_eval u_eval (
        .i_slot0     (cell_q[6]),
        .i_slot1     (cell_q[5]),
        .i_slot2     (cell_q[4]),
        .i_slot3     (cell_q[3]),
        .i_slot4     (cell_q[2]),
        .i_slot5     (cell_q[1]),
        .i_slot6     (cell_q[0]),
        .i_slot7     (i_rx_byte),
        .i_threshold (r_threshold),
        .o_result    (result)
    );

    // Output register: load on frame completion, drop once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (complete) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (complete) begin
            r_out <= result;
        end
    end

    assign o_res_valid       = r_out_valid;
    assign o_frame_ok        = r_out.frame_ok;
    assign o_temp_tens_char  = r_out.temp_tens_char;
    assign o_temp_units_char = r_out.temp_units_char;
    assign o_hum_tens_char   = r_out.hum_tens_char;
    assign o_hum_units_char  = r_out.hum_units_char;
    assign o_temperature     = r_out.temperature;
    assign o_over_threshold  = r_out.over_threshold;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RST;
        end else if (cfg_write && (paddr[2] == REG_THRESH)) begin
            r_threshold <= pwdata[7:0];
        end
    end

    // Read back; paddr[1:0] is the byte lane and does not select a register.
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_THRESH: prdata = {24'd0, r_threshold};
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- rtl/sfra_checker.sv -----
// Port-level checks of the frame receiver, bound to the top level.
`include "sensor_frame_receiver_alarm_core_macros.svh"

module sfra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_rx_ready,
    input logic       o_res_valid,
    input logic       i_res_ready,
    input logic       o_frame_ok,
    input logic [7:0] o_temperature,
    input logic       o_over_threshold
);
    import sfra_pkg::*;

    // A stalled result keeps its value.
    `SFRA_ASSERT_NEXT(a_res_hold, o_res_valid && !i_res_ready, o_res_valid && $stable(o_temperature))

    // The alarm only comes with a well-formed frame.
    `SFRA_ASSERT_NOW(a_alarm_needs_ok, o_res_valid && o_over_threshold, o_frame_ok)

    // Input is only held off behind a pending result beat.
    `SFRA_ASSERT_NOW(a_ready_when_empty, !o_res_valid, o_rx_ready)

endmodule

bind sensor_frame_receiver_alarm_core sfra_checker u_sfra_checker (.*);

// ----- verif/testbench.sv -----
// Self-checking testbench for the sensor frame receiver with temperature alarm.
module testbench;
    import sfra_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES = 4;

    // Register byte addresses
    localparam logic [2:0] ADDR_THRESH = 3'd0;
    localparam logic [2:0] ADDR_SPARE  = 3'd4;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic        o_frame_ok;
    logic [7:0]  o_temp_tens_char;
    logic [7:0]  o_temp_units_char;
    logic [7:0]  o_hum_tens_char;
    logic [7:0]  o_hum_units_char;
    logic [7:0]  o_temperature;
    logic        o_over_threshold;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    sensor_frame_receiver_alarm_core u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_ready       (i_res_ready),
        .o_frame_ok        (o_frame_ok),
        .o_temp_tens_char  (o_temp_tens_char),
        .o_temp_units_char (o_temp_units_char),
        .o_hum_tens_char   (o_hum_tens_char),
        .o_hum_units_char  (o_hum_units_char),
        .o_temperature     (o_temperature),
        .o_over_threshold  (o_over_threshold),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #6 i_clk = ~i_clk;

    // Stimulus and expectation stores
    logic [7:0]  rx_byte_q[$];
    t_result     frame_results_q[$];

    // Shadow of the block's frame assembly state
    logic [7:0]  frame_bytes [0:7];
    logic [2:0]  slot_pos = 3'd0;
    logic        in_frame = 1'b0;
    logic [7:0]  alarm_level = THRESH_RST;

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;
    int unsigned bytes_taken = 0;
    int unsigned frames_checked = 0;
    int unsigned good_frames = 0;
    int unsigned alarms_seen = 0;
    int unsigned cycle_count = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
    endtask

    // Advance the frame shadow by one accepted byte; queue a result on slot 7
    task automatic assemble_frame(input logic [7:0] rx);
        t_result    res;
        logic [7:0] tens_val;
        logic [7:0] units_val;
        if (rx == CH_START && slot_pos == 3'd0) begin
            frame_bytes[0] = rx;
            in_frame = 1'b1;
        end else if (in_frame) begin
            slot_pos = slot_pos + 3'd1;
            frame_bytes[slot_pos] = rx;
            if (slot_pos == LAST_SLOT) begin
                slot_pos = 3'd0;
                in_frame = 1'b0;
                tens_val = frame_bytes[3] - CH_ZERO;
                units_val = frame_bytes[4] - CH_ZERO;
                res.frame_ok = frame_bytes[0] == CH_START && frame_bytes[1] == CH_HEAD &&
                               frame_bytes[2] == CH_HEAD && frame_bytes[7] == CH_TAIL;
                res.temp_tens_char = frame_bytes[3];
                res.temp_units_char = frame_bytes[4];
                res.hum_tens_char = frame_bytes[5];
                res.hum_units_char = frame_bytes[6];
                res.temperature = tens_val * TEN + units_val;
                res.over_threshold = res.frame_ok && (res.temperature >= alarm_level);
                frame_results_q.push_back(res);
            end
        end
    endtask

    // Sender: account for the accepted beat, then present the next one or go idle
    always @(posedge i_clk) begin : rx_driver
        logic fire;
        fire = i_rx_valid && o_rx_ready;
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (fire) begin
                assemble_frame(i_rx_byte);
                bytes_taken++;
            end
            if (!i_rx_valid || fire) begin
                if (rx_byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_rx_byte <= rx_byte_q.pop_front();
                    i_rx_valid <= 1'b1;
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result beat against the oldest expectation, stall at random
    always @(posedge i_clk) begin : res_monitor
        t_result want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (frame_results_q.size() == 0) begin
                report_mismatch("unexpected result", {7'd0, o_frame_ok}, 8'h00);
            end else begin
                want = frame_results_q.pop_front();
                frames_checked++;
                if (want.frame_ok) good_frames++;
                if (want.over_threshold) alarms_seen++;
                if (o_frame_ok !== want.frame_ok)
                    report_mismatch("frame_ok", {7'd0, o_frame_ok}, {7'd0, want.frame_ok});
                if (o_temp_tens_char !== want.temp_tens_char)
                    report_mismatch("temp_tens_char", o_temp_tens_char, want.temp_tens_char);
                if (o_temp_units_char !== want.temp_units_char)
                    report_mismatch("temp_units_char", o_temp_units_char, want.temp_units_char);
                if (o_hum_tens_char !== want.hum_tens_char)
                    report_mismatch("hum_tens_char", o_hum_tens_char, want.hum_tens_char);
                if (o_hum_units_char !== want.hum_units_char)
                    report_mismatch("hum_units_char", o_hum_units_char, want.hum_units_char);
                if (o_temperature !== want.temperature)
                    report_mismatch("temperature", o_temperature, want.temperature);
                if (o_over_threshold !== want.over_threshold)
                    report_mismatch("over_threshold", {7'd0, o_over_threshold},
                                    {7'd0, want.over_threshold});
            end
        end
        i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sensor_frame_receiver_alarm_core verification failed");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_THRESH) alarm_level = data[7:0];
    endtask

    // Read the threshold back and compare with the shadow copy
    task automatic verify_threshold();
        logic [7:0] got;
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_THRESH;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        got = prdata[7:0];
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== alarm_level) report_mismatch("temp_threshold readback", got, alarm_level);
    endtask

    // Hold until every queued byte is taken and every expected result has arrived
    task automatic drain_traffic();
        while (rx_byte_q.size() > 0 || i_rx_valid || frame_results_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [7:0] digit_char();
        if ($urandom_range(99) < 85) return CH_ZERO + 8'($urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed frames with random content; some noise and cut-off frames
    task automatic queue_sensor_traffic(input int unsigned n_bytes);
        int unsigned made;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  frame [0:7];
        made = 0;
        while (made < n_bytes) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                frame[0] = CH_START;
                frame[1] = CH_HEAD;
                frame[2] = CH_HEAD;
                for (int k = 3; k < 7; k++) frame[k] = digit_char();
                frame[7] = CH_TAIL;
                if ($urandom_range(99) < 20) frame[$urandom_range(7)] = 8'($urandom_range(255));
                if ($urandom_range(99) < 10) rx_byte_q.push_back(CH_START);
                for (int k = 0; k < 8; k++) rx_byte_q.push_back(frame[k]);
                made += 8;
            end else if (pick < 90) begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) rx_byte_q.push_back(8'($urandom_range(255)));
            end else begin
                n = $urandom_range(1, 6);
                rx_byte_q.push_back(CH_START);
                for (int k = 0; k < n; k++) rx_byte_q.push_back(digit_char());
                made += n + 1;
            end
        end
    endtask

    initial begin
        logic [7:0] opening [0:26];
        opening = '{8'h00, 8'hFF,
                    CH_START, CH_START, CH_HEAD, CH_HEAD,
                    CH_ZERO + 8'd2, CH_ZERO + 8'd5, CH_ZERO + 8'd6, CH_ZERO, CH_TAIL,
                    CH_START, CH_HEAD, CH_HEAD,
                    CH_ZERO + 8'd1, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_ZERO + 8'd9, CH_TAIL,
                    CH_START, 8'hFF, CH_HEAD, 8'h00, 8'hFF, CH_START, CH_HEAD, CH_TAIL};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset threshold, no idling, directed frames first
        verify_threshold();
        for (int k = 0; k < 27; k++) rx_byte_q.push_back(opening[k]);
        queue_sensor_traffic(280);
        drain_traffic();

        // Threshold at zero, sender mostly idle
        apb_write(ADDR_THRESH, 32'hA5A5_A500);
        verify_threshold();
        send_idle_pct = 75;
        recv_stall_pct = 0;
        queue_sensor_traffic(300);
        drain_traffic();

        // Threshold at maximum, receiver mostly stalled, one frame reaching 255
        apb_write(ADDR_THRESH, 32'h5A5A_5AFF);
        verify_threshold();
        send_idle_pct = 0;
        recv_stall_pct = 75;
        rx_byte_q.push_back(CH_START);
        rx_byte_q.push_back(CH_HEAD);
        rx_byte_q.push_back(CH_HEAD);
        rx_byte_q.push_back(CH_ZERO + 8'd25);
        rx_byte_q.push_back(CH_ZERO + 8'd5);
        rx_byte_q.push_back(CH_ZERO + 8'd4);
        rx_byte_q.push_back(CH_ZERO + 8'd2);
        rx_byte_q.push_back(CH_TAIL);
        queue_sensor_traffic(300);
        drain_traffic();

        // Random threshold, both sides idling, with a full drain midway
        apb_write(ADDR_THRESH, $urandom());
        verify_threshold();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        queue_sensor_traffic(150);
        drain_traffic();
        queue_sensor_traffic(150);
        drain_traffic();

        // Write to an unmapped address must leave the threshold alone
        apb_write(ADDR_THRESH, 32'h0000_0025);
        apb_write(ADDR_SPARE, 32'hFFFF_FF07);
        verify_threshold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        queue_sensor_traffic(300);
        drain_traffic();

        if (frame_results_q.size() != 0)
            report_mismatch("results never delivered", 8'(frame_results_q.size()), 8'h00);
        $display("covered %0d bytes and %0d frames (%0d well formed, %0d alarms)",
                 bytes_taken, frames_checked, good_frames, alarms_seen);
        $display("thresholds 20, 0, 255, random and 37 with idle and stall phases");
        if (error_count == 0) begin
            $display("sensor_frame_receiver_alarm_core verification clean");
        end else begin
            $display("sensor_frame_receiver_alarm_core verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sfra_pkg.sv
rtl/sfra_cell.sv
rtl/sfra_eval.sv
rtl/sensor_frame_receiver_alarm_core.sv
rtl/sfra_checker.sv
verif/testbench.sv
